/* rtl/mcuct_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the multi-channel countdown timer.
// No dependencies; the core and the decrement unit refer to it by scoped names.
package mcuct_pkg;

  // Default channel count of the timer table
  localparam int CHANNELS_DEF = 16;

  // Field widths fixed by the interface
  localparam int CH_W    = 4;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;
  localparam int UNIT_W  = 2;
  localparam int CFG_W   = 16;

  // Input kind codes
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RUN_ENABLE     = 2'd0;
  localparam logic [1:0] REG_LAST_CHANNEL   = 2'd1;
  localparam logic [1:0] REG_SUSPENDED_MASK = 2'd2;

  // Unit codes in bits 7:6 of a timer byte
  localparam logic [1:0] UNIT_20MS  = 2'd0;
  localparam logic [1:0] UNIT_100MS = 2'd1;
  localparam logic [1:0] UNIT_1S    = 2'd2;
  localparam logic [1:0] UNIT_10S   = 2'd3;

  // Last value of each prescaler before it wraps (wraps at 5, 50, 500)
  localparam logic [2:0] P100_LAST = 3'd4;
  localparam logic [5:0] P1S_LAST  = 6'd49;
  localparam logic [8:0] P10S_LAST = 9'd499;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // Prescalers sitting at zero after the current tick's advance
  typedef struct packed {
    logic z100;
    logic z1s;
    logic z10s;
  } presc_zero_t;

  // Verdict of the decrement unit for one channel
  typedef struct packed {
    logic              due;
    logic              fire;
    logic              wr;
    logic [BYTE_W-1:0] byte_next;
  } eval_t;

endpackage

/* rtl/multi_channel_unit_countdown_timer_core.sv */
`timescale 1ns / 1ps
// Top level of the multi-channel countdown timer: sequencer, prescalers, config.
// Depends on mcuct_pkg, mcuct_ram and mcuct_eval.
//
//  channel   signals                                  beat taken when
//  -------   --------------------------------------   -------------------------
//  command   start, busy, kind, channel, timer_byte   start && !busy
//  result    result_valid, fired, channel_out,        result_valid (one cycle)
//            timer_out, last
//  config    cfg_write, cfg_index, cfg_data           cfg_write
//
// A load or a tick with run off leaves the sequencer in ST_IDLE; a read passes
// through ST_READ and its result is registered out of it. A running tick passes
// through ST_SCAN, ST_DRAIN and ST_FLUSH (straight to ST_FLUSH when the scan bound
// is zero): the scan reads one table entry per cycle through the single RAM read
// port and the shared decrement unit, which judges each entry in the cycle after its read.
// rst is synchronous; it clears the table's valid bits, so every entry reads
// as idle, with no clearing pass. Results cannot be stalled.
module multi_channel_unit_countdown_timer_core #(
  parameter int CHANNELS = mcuct_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [mcuct_pkg::CH_W-1:0]    channel,
  input  logic [mcuct_pkg::BYTE_W-1:0]  timer_byte,
  // results
  output logic                          result_valid,
  output logic                          fired,
  output logic [mcuct_pkg::CH_W-1:0]    channel_out,
  output logic [mcuct_pkg::BYTE_W-1:0]  timer_out,
  output logic                          last,
  // configuration
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mcuct_pkg::CFG_W-1:0]   cfg_data
);

  localparam int AW      = $clog2(CHANNELS);
  localparam int MAX_IDX = CHANNELS - 1;

  // Configuration registers
  logic                         run_enable;
  logic [mcuct_pkg::CH_W-1:0]   last_channel;
  logic [mcuct_pkg::CFG_W-1:0]  suspended_mask;

  // Sequencer and scan state
  mcuct_pkg::state_t            state, state_next;
  logic [mcuct_pkg::CH_W-1:0]   ptr;
  logic                         ev_go;
  logic [mcuct_pkg::CH_W-1:0]   ev_ch;
  logic                         pend_valid;
  logic [mcuct_pkg::CH_W-1:0]   pend_ch;
  logic [mcuct_pkg::CH_W-1:0]   op_ch;
  logic                         op_in_range;
  logic                         vld_q;

  // Prescalers
  logic [2:0]                   p100;
  logic [5:0]                   p1s;
  logic [8:0]                   p10s;

  // Valid bit per table entry
  logic [2**AW-1:0]             vld;

  // Control
  logic                         accept;
  logic                         tick_run;
  logic                         load_wr;
  logic                         in_range;
  logic [mcuct_pkg::CH_W-1:0]   lim;
  logic                         scanning;
  logic                         eval_en;
  logic                         fire_now;

  // RAM port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [mcuct_pkg::BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [mcuct_pkg::BYTE_W-1:0] ram_rdata;
  logic [mcuct_pkg::BYTE_W-1:0] entry;

  mcuct_pkg::presc_zero_t       pz;
  mcuct_pkg::eval_t             verdict;

  // Scan bound: last_channel capped at the table's top index
  assign lim      = (int'(last_channel) > MAX_IDX) ? mcuct_pkg::CH_W'(MAX_IDX) : last_channel;
  assign in_range = int'(channel) < CHANNELS;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable     <= 1'b0;
      last_channel   <= '0;
      suspended_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mcuct_pkg::REG_RUN_ENABLE:     run_enable     <= cfg_data[0];
        mcuct_pkg::REG_LAST_CHANNEL:   last_channel   <= cfg_data[mcuct_pkg::CH_W-1:0];
        mcuct_pkg::REG_SUSPENDED_MASK: suspended_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mcuct_pkg::ST_IDLE: begin
        if (start) begin
          if (kind == mcuct_pkg::KIND_TICK && run_enable) begin
            state_next = (lim == '0) ? mcuct_pkg::ST_FLUSH : mcuct_pkg::ST_SCAN;
          end else if (kind == mcuct_pkg::KIND_READ) begin
            state_next = mcuct_pkg::ST_READ;
          end
        end
      end
      mcuct_pkg::ST_READ:  state_next = mcuct_pkg::ST_IDLE;
      mcuct_pkg::ST_SCAN: begin
        if (ptr == lim) begin
          state_next = mcuct_pkg::ST_DRAIN;
        end
      end
      mcuct_pkg::ST_DRAIN: state_next = mcuct_pkg::ST_FLUSH;
      mcuct_pkg::ST_FLUSH: state_next = mcuct_pkg::ST_IDLE;
      default:             state_next = mcuct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcuct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control outputs of the sequencer
  always_comb begin
    busy     = (state != mcuct_pkg::ST_IDLE);
    accept   = start && !busy;
    tick_run = accept && (kind == mcuct_pkg::KIND_TICK) && run_enable;
    load_wr  = accept && (kind == mcuct_pkg::KIND_LOAD) && in_range;
    scanning = (state == mcuct_pkg::ST_SCAN) || (state == mcuct_pkg::ST_DRAIN);
    eval_en  = scanning && ev_go;
    fire_now = eval_en && verdict.fire;

    ram_raddr = (state == mcuct_pkg::ST_IDLE) ? AW'(channel) : AW'(ptr);
    if (eval_en && verdict.wr) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ev_ch);
      ram_wdata = verdict.byte_next;
    end else begin
      ram_we    = load_wr;
      ram_waddr = AW'(channel);
      ram_wdata = timer_byte;
    end
  end

  // Prescalers advance once per running tick
  always_ff @(posedge clk) begin
    if (rst) begin
      p100 <= '0;
      p1s  <= '0;
      p10s <= '0;
    end else if (tick_run) begin
      p100 <= (p100 == mcuct_pkg::P100_LAST) ? '0 : p100 + 1'b1;
      p1s  <= (p1s  == mcuct_pkg::P1S_LAST)  ? '0 : p1s  + 1'b1;
      p10s <= (p10s == mcuct_pkg::P10S_LAST) ? '0 : p10s + 1'b1;
    end
  end

  assign pz.z100 = (p100 == '0);
  assign pz.z1s  = (p1s  == '0);
  assign pz.z10s = (p10s == '0);

  // Timer table
  mcuct_ram #(
    .WIDTH (mcuct_pkg::BYTE_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Valid bits: an entry never loaded reads as idle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (load_wr) begin
      vld[AW'(channel)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[ram_raddr];
  end

  assign entry = vld_q ? ram_rdata : '0;

  mcuct_eval u_eval (
    .timer_byte (entry),
    .pz         (pz),
    .verdict    (verdict)
  );

  // Scan pointer and evaluation stage, which judges an entry in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_go <= 1'b0;
    end else if (state == mcuct_pkg::ST_SCAN) begin
      ev_go <= !suspended_mask[ptr];
    end else begin
      ev_go <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_run) begin
      ptr <= mcuct_pkg::CH_W'(1);
    end else if (state == mcuct_pkg::ST_SCAN && ptr != lim) begin
      ptr <= ptr + 1'b1;
    end
    ev_ch <= ptr;
  end

  // Operand latch for a read
  always_ff @(posedge clk) begin
    if (accept) begin
      op_ch       <= channel;
      op_in_range <= in_range;
    end
  end

  // One fire report held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (fire_now) begin
      pend_valid <= 1'b1;
    end else if (state == mcuct_pkg::ST_FLUSH) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_now) begin
      pend_ch <= ev_ch;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == mcuct_pkg::ST_READ) ||
                      (fire_now && pend_valid) ||
                      ((state == mcuct_pkg::ST_FLUSH) && pend_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcuct_pkg::ST_READ) begin
      fired       <= 1'b0;
      channel_out <= op_ch;
      timer_out   <= op_in_range ? entry : '0;
      last        <= 1'b1;
    end else begin
      fired       <= 1'b1;
      channel_out <= pend_ch;
      timer_out   <= '0;
      last        <= (state == mcuct_pkg::ST_FLUSH);
    end
  end

  // Checks
  a_scan_ptr_bounds: assert property (@(posedge clk) disable iff (rst)
    state == mcuct_pkg::ST_SCAN |-> (ptr != '0) && (ptr <= lim))
    else $error("scan pointer outside channel range");

  a_wb_not_read_addr: assert property (@(posedge clk) disable iff (rst)
    (state == mcuct_pkg::ST_SCAN) && ram_we |-> ram_waddr != ram_raddr)
    else $error("write-back collides with scan read");

  a_no_pend_in_idle: assert property (@(posedge clk) disable iff (rst)
    state == mcuct_pkg::ST_IDLE |-> !pend_valid)
    else $error("fire report left behind after scan");

  a_fire_beat_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && fired |-> timer_out == '0)
    else $error("fire report carries timer data");

  a_read_beat_last: assert property (@(posedge clk) disable iff (rst)
    $past(state) == mcuct_pkg::ST_READ |-> result_valid && last && !fired)
    else $error("read answer missing");

endmodule

/* rtl/mcuct_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mcuct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mcuct_eval.sv */
`timescale 1ns / 1ps
// Shared decrement and compare unit: judges one timer byte per cycle.
// Depends on mcuct_pkg for the unit codes and the verdict struct.
module mcuct_eval (
  input  logic [mcuct_pkg::BYTE_W-1:0] timer_byte,
  input  mcuct_pkg::presc_zero_t       pz,
  output mcuct_pkg::eval_t             verdict
);

  logic [mcuct_pkg::UNIT_W-1:0]  unit;
  logic [mcuct_pkg::COUNT_W-1:0] cnt;
  logic [mcuct_pkg::COUNT_W-1:0] dec;
  logic                          unit_due;

  assign unit = timer_byte[mcuct_pkg::BYTE_W-1 -: mcuct_pkg::UNIT_W];
  assign cnt  = timer_byte[mcuct_pkg::COUNT_W-1:0];
  assign dec  = cnt - 1'b1;

  // Unit selects which prescaler must be at zero
  always_comb begin
    case (unit)
      mcuct_pkg::UNIT_20MS:  unit_due = 1'b1;
      mcuct_pkg::UNIT_100MS: unit_due = pz.z100;
      mcuct_pkg::UNIT_1S:    unit_due = pz.z1s;
      mcuct_pkg::UNIT_10S:   unit_due = pz.z10s;
      default:               unit_due = 1'b0;
    endcase
  end

  // A zero count is idle; reaching zero fires and leaves the byte alone
  always_comb begin
    verdict.due       = unit_due && (cnt != '0);
    verdict.fire      = verdict.due && (dec == '0);
    verdict.wr        = verdict.due && (dec != '0);
    verdict.byte_next = {unit, dec};
  end

endmodule
